// ===== hdl/htkv_pkg.sv =====
// Shared types, constants and the control store of the hash trie key/value map.
// Used by the interfaces, the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package htkv_pkg;

  localparam int unsigned DigitBits = 4;
  localparam int unsigned Fanout    = 1 << DigitBits;
  localparam int unsigned KeyBytes  = 8;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CntW      = 5;
  localparam int unsigned DigitIdxW = 4;
  localparam int unsigned StepW     = 4;

  localparam logic [0:0] ActLookup = 1'b0;
  localparam logic [0:0] ActUpdate = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LINK_ADV,
    OP_CREATE,
    OP_EMIT_LOOKUP,
    OP_EMIT_FULL,
    OP_STORE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_DEPTH_END,
    C_DEPTH_MORE,
    C_LINK_SET,
    C_LOOKUP,
    C_NO_ROOM
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             wait_out;
  } ctrl_word_t;

  typedef struct packed {
    logic req_fire;
    logic depth_end;
    logic link_set;
    logic is_lookup;
    logic no_room;
    logic out_busy;
  } status_t;

  localparam logic [StepW-1:0] S_IDLE   = 4'd0;
  localparam logic [StepW-1:0] S_WALK   = 4'd1;
  localparam logic [StepW-1:0] S_FOLLOW = 4'd2;
  localparam logic [StepW-1:0] S_DECIDE = 4'd3;
  localparam logic [StepW-1:0] S_ROOM   = 4'd4;
  localparam logic [StepW-1:0] S_CREATE = 4'd5;
  localparam logic [StepW-1:0] S_FETCH  = 4'd6;
  localparam logic [StepW-1:0] S_STORE  = 4'd7;
  localparam logic [StepW-1:0] S_LOOKUP = 4'd8;
  localparam logic [StepW-1:0] S_FULL   = 4'd9;

  function automatic ctrl_word_t ctrl_rom(input logic [StepW-1:0] step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:   w = '{op: OP_ACCEPT,      cond: C_NO_REQ,     target: S_IDLE,   wait_out: 1'b0};
      S_WALK:   w = '{op: OP_NONE,        cond: C_DEPTH_END,  target: S_DECIDE, wait_out: 1'b0};
      S_FOLLOW: w = '{op: OP_LINK_ADV,    cond: C_LINK_SET,   target: S_WALK,   wait_out: 1'b0};
      S_DECIDE: w = '{op: OP_NONE,        cond: C_LOOKUP,     target: S_LOOKUP, wait_out: 1'b0};
      S_ROOM:   w = '{op: OP_NONE,        cond: C_NO_ROOM,    target: S_FULL,   wait_out: 1'b0};
      S_CREATE: w = '{op: OP_CREATE,      cond: C_DEPTH_MORE, target: S_CREATE, wait_out: 1'b0};
      S_FETCH:  w = '{op: OP_NONE,        cond: C_NEVER,      target: S_IDLE,   wait_out: 1'b0};
      S_STORE:  w = '{op: OP_STORE,       cond: C_ALWAYS,     target: S_IDLE,   wait_out: 1'b1};
      S_LOOKUP: w = '{op: OP_EMIT_LOOKUP, cond: C_ALWAYS,     target: S_IDLE,   wait_out: 1'b1};
      S_FULL:   w = '{op: OP_EMIT_FULL,   cond: C_ALWAYS,     target: S_IDLE,   wait_out: 1'b1};
      default:  w = '{op: OP_NONE,        cond: C_ALWAYS,     target: S_IDLE,   wait_out: 1'b0};
    endcase
    return w;
  endfunction

  // Twice the number of significant key bytes.
  function automatic logic [CntW-1:0] digit_count(input logic [KeyW-1:0] key);
    logic [CntW-1:0] cnt;
    cnt = '0;
    for (int b = 0; b < KeyBytes; b++) begin
      if (key[b*8 +: 8] != 8'd0) begin
        cnt = CntW'((b + 1) * 2);
      end
    end
    return cnt;
  endfunction

endpackage

// ===== hdl/htkv_if.sv =====
// Request and response channel interfaces of the hash trie key/value map.
// Depends on htkv_pkg for field widths.
`timescale 1ns / 1ps

interface htkv_req_if import htkv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [KeyW-1:0]         hashed_key;
  logic signed [DataW-1:0] new_value;
  logic signed [DataW-1:0] new_version;

  modport source (output valid, action, hashed_key, new_value, new_version, input ready);
  modport sink   (input valid, action, hashed_key, new_value, new_version, output ready);
endinterface

interface htkv_rsp_if import htkv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [DataW-1:0] out_value;
  logic signed [DataW-1:0] out_version;
  logic                    pool_full;

  modport source (output valid, found, out_value, out_version, pool_full, input ready);
  modport sink   (input valid, found, out_value, out_version, pool_full, output ready);
endinterface

// ===== hdl/htkv_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on htkv_pkg for the control word, status struct and program.
`timescale 1ns / 1ps

module htkv_seq import htkv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  status_t    status_i,
  output ctrl_word_t ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  ctrl_word_t       ctrl;
  logic             taken;

  assign ctrl   = ctrl_rom(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_REQ:     taken = !status_i.req_fire;
      C_DEPTH_END:  taken = status_i.depth_end;
      C_DEPTH_MORE: taken = !status_i.depth_end;
      C_LINK_SET:   taken = status_i.link_set;
      C_LOOKUP:     taken = status_i.is_lookup;
      C_NO_ROOM:    taken = status_i.no_room;
      default:      taken = 1'b1;
    endcase
  end

  always_comb begin
    priority if (ctrl.wait_out && status_i.out_busy) begin
      step_d = step_q;
    end else if (taken) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hdl/htkv_dpath.sv =====
// Datapath: request registers, link and node memories, free counter, result register.
// Depends on htkv_pkg and the htkv_req_if / htkv_rsp_if channel interfaces.
`timescale 1ns / 1ps

module htkv_dpath import htkv_pkg::*; #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctrl_word_t   ctrl_i,
  output status_t      status_o,
  htkv_req_if.sink     req_i,
  htkv_rsp_if.source   rsp_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned LW = NW + DigitBits;
  localparam int unsigned LinkDepth = NODE_COUNT * Fanout;
  localparam int unsigned RoomW = NW + 2;

  logic [NW-1:0]    link_mem [LinkDepth];
  logic [DataW-1:0] val_mem  [NODE_COUNT];
  logic [DataW-1:0] ver_mem  [NODE_COUNT];

  logic                 action_q;
  logic [KeyW-1:0]      key_q;
  logic [DataW-1:0]     value_q, version_q;
  logic [CntW-1:0]      n_q, n_d, j_q, j_d;
  logic [NW-1:0]        node_q, node_d;
  logic [NW:0]          free_q, free_d;
  logic                 clr_busy_q;
  logic [LW-1:0]        clr_q;
  logic [NW-1:0]        link_rd_q;
  logic [DataW-1:0]     val_rd_q, ver_rd_q;
  logic                 out_valid_q;
  logic                 found_q, full_q;
  logic [DataW-1:0]     out_val_q, out_ver_q;

  logic [DigitBits-1:0] digit;
  logic [LW-1:0]        link_addr;
  logic                 depth_end, link_set, out_busy, fire;
  logic                 create_en, store_en, emit_en;
  logic [DataW-1:0]     ver_new;

  assign digit     = key_q[{j_q[DigitIdxW-1:0], 2'b00} +: DigitBits];
  assign link_addr = {node_q, digit};
  assign depth_end = (j_q == n_q);
  assign link_set  = (link_rd_q != '0);
  assign out_busy  = out_valid_q && !rsp_o.ready;

  assign req_i.ready = (ctrl_i.op == OP_ACCEPT) && !clr_busy_q;
  assign fire        = req_i.valid && req_i.ready;

  assign create_en = (ctrl_i.op == OP_CREATE) && !depth_end;
  assign store_en  = (ctrl_i.op == OP_STORE) && !out_busy;
  assign emit_en   = !out_busy && (ctrl_i.op == OP_STORE || ctrl_i.op == OP_EMIT_LOOKUP
                                   || ctrl_i.op == OP_EMIT_FULL);

  assign ver_new = ($signed(version_q) > 0) ? version_q : ver_rd_q + DataW'(1);

  assign status_o.req_fire  = fire;
  assign status_o.depth_end = depth_end;
  assign status_o.link_set  = link_set;
  assign status_o.is_lookup = (action_q == ActLookup);
  assign status_o.no_room   = ({1'b0, free_q} + RoomW'(n_q - j_q)) > RoomW'(NODE_COUNT);
  assign status_o.out_busy  = out_busy;

  always_comb begin
    n_d    = n_q;
    j_d    = j_q;
    node_d = node_q;
    free_d = free_q;
    unique case (ctrl_i.op)
      OP_ACCEPT: begin
        if (fire) begin
          n_d    = digit_count(req_i.hashed_key);
          j_d    = '0;
          node_d = '0;
        end
      end
      OP_LINK_ADV: begin
        if (link_set) begin
          node_d = link_rd_q;
          j_d    = j_q + CntW'(1);
        end
      end
      OP_CREATE: begin
        if (!depth_end) begin
          node_d = free_q[NW-1:0];
          j_d    = j_q + CntW'(1);
          free_d = free_q + (NW+1)'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      j_q         <= '0;
      node_q      <= '0;
      free_q      <= (NW+1)'(1);
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      action_q    <= ActLookup;
    end else begin
      n_q    <= n_d;
      j_q    <= j_d;
      node_q <= node_d;
      free_q <= free_d;
      if (fire) begin
        action_q <= req_i.action;
      end
      if (clr_busy_q) begin
        clr_q <= clr_q + LW'(1);
        if (clr_q == LW'(LinkDepth - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request payload and result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      key_q     <= req_i.hashed_key;
      value_q   <= req_i.new_value;
      version_q <= req_i.new_version;
    end
    if (emit_en) begin
      unique case (ctrl_i.op)
        OP_STORE: begin
          found_q   <= 1'b1;
          full_q    <= 1'b0;
          out_val_q <= value_q;
          out_ver_q <= ver_new;
        end
        OP_EMIT_FULL: begin
          found_q   <= 1'b0;
          full_q    <= 1'b1;
          out_val_q <= '1;
          out_ver_q <= '1;
        end
        default: begin
          found_q   <= depth_end;
          full_q    <= 1'b0;
          out_val_q <= depth_end ? val_rd_q : '1;
          out_ver_q <= depth_end ? ver_rd_q : '1;
        end
      endcase
    end
  end

  // Link memory: clear sweep after reset, then child creation.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      link_mem[clr_q] <= '0;
    end else if (create_en) begin
      link_mem[link_addr] <= free_q[NW-1:0];
    end
    link_rd_q <= link_mem[link_addr];
  end

  // Node value and version memories.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      val_mem[clr_q[LW-1:DigitBits]] <= '0;
      ver_mem[clr_q[LW-1:DigitBits]] <= '0;
    end else if (store_en) begin
      val_mem[node_q] <= value_q;
      ver_mem[node_q] <= ver_new;
    end
    val_rd_q <= val_mem[node_q];
    ver_rd_q <= ver_mem[node_q];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.pool_full   = full_q;
  assign rsp_o.out_value   = out_val_q;
  assign rsp_o.out_version = out_ver_q;

endmodule

// ===== hdl/hash_trie_key_value_map_unit.sv =====
// Operation: a lookup follows one link per trie level through the registered link memory
// read; an update also creates one new node for each missing level, or reports a full pool.
// One request at a time, the next accepted after the result is registered. After reset
// the link and node memories are cleared, during which no request is accepted; the free
// counter resets to 1.
`timescale 1ns / 1ps

module hash_trie_key_value_map_unit import htkv_pkg::*; #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htkv_req_if.sink   req_i,
  htkv_rsp_if.source rsp_o
);

  ctrl_word_t ctrl;
  status_t    status;

  htkv_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  htkv_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .req_i    (req_i),
    .rsp_o    (rsp_o)
  );

endmodule
